// ===== rtl/trcs_pkg.sv =====
package trcs_pkg;

    // Fixed field widths of the two channels and of the opcode.
    localparam int DATA_W    = 16;
    localparam int OPN_W     = 2;
    localparam int IN_ADDR_W = 6;
    localparam int PC_OUT_W  = 6;
    localparam int OPC_W     = 8;

    // Defaults for the top level parameters.
    localparam int MEM_WORDS_DEF = 64;
    localparam int REG_COUNT_DEF = 16;

    // Host operations carried by one input beat.
    localparam logic [OPN_W-1:0] OPN_EXEC  = 2'd0;
    localparam logic [OPN_W-1:0] OPN_WRITE = 2'd1;
    localparam logic [OPN_W-1:0] OPN_READ  = 2'd2;

    // Instruction opcodes, bits 15..8 of an instruction word.
    localparam logic [OPC_W-1:0] OP_MOV   = 8'h00;
    localparam logic [OPC_W-1:0] OP_ADD   = 8'h01;
    localparam logic [OPC_W-1:0] OP_SUB   = 8'h02;
    localparam logic [OPC_W-1:0] OP_MUL   = 8'h03;
    localparam logic [OPC_W-1:0] OP_DIV   = 8'h04;
    localparam logic [OPC_W-1:0] OP_LOAD  = 8'h05;
    localparam logic [OPC_W-1:0] OP_STORE = 8'h06;
    localparam logic [OPC_W-1:0] OP_JNZ   = 8'h07;
    localparam logic [OPC_W-1:0] OP_JMP   = 8'h08;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_load;
        logic host_wr;
        logic host_rd;
        logic rd_cap;
        logic fetch;
        logic ir_load;
        logic reg_rd;
        logic exec;
        logic div_wr;
        logic out_load;
    } trcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic halted;
        logic is_div;
        logic div_done;
    } trcs_sts_t;

    // Remainder of an 8-bit value by a modulus, by four restoring
    // compare-and-subtract steps. The quotient must stay below sixteen,
    // which holds for memory addresses and for register indexes alike.
    function automatic logic [7:0] wrap_mod(input logic [7:0] value,
                                            input logic [8:0] modulus);
        logic [12:0] rem;
        logic [12:0] step;
        rem = {5'b0, value};
        for (int i = 3; i >= 0; i--) begin
            step = {4'b0, modulus} << i;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[7:0];
    endfunction

endpackage

// ===== rtl/trcs_div.sv =====
module trcs_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [trcs_pkg::DATA_W-1:0]  dividend,
    input  logic [trcs_pkg::DATA_W-1:0]  divisor,
    output logic                         done,
    output logic [trcs_pkg::DATA_W-1:0]  quotient
);
    import trcs_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    // One quotient bit per cycle. A zero divisor always fits, so the
    // quotient comes out as all ones without a special case.
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/trcs_datapath.sv =====
module trcs_datapath #(
    parameter int MEM_WORDS = trcs_pkg::MEM_WORDS_DEF,
    parameter int REG_COUNT = trcs_pkg::REG_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  trcs_pkg::trcs_cmd_t             cmd,
    output trcs_pkg::trcs_sts_t             sts,
    input  logic [trcs_pkg::IN_ADDR_W-1:0]  s_address,
    input  logic [trcs_pkg::DATA_W-1:0]     s_write_data,
    output logic [trcs_pkg::PC_OUT_W-1:0]   m_program_counter,
    output logic                            m_halted,
    output logic [trcs_pkg::DATA_W-1:0]     m_read_data,
    output logic [trcs_pkg::DATA_W-1:0]     m_accumulator
);
    import trcs_pkg::*;

    localparam int MAW = $clog2(MEM_WORDS);
    localparam int RIW = $clog2(REG_COUNT);
    localparam logic [8:0]     MEM_MOD  = 9'(MEM_WORDS);
    localparam logic [8:0]     REG_MOD  = 9'(REG_COUNT);
    localparam logic [MAW-1:0] PC_LAST  = MAW'(MEM_WORDS - 1);

    // Shared instruction and data memory, and the register file.
    logic [DATA_W-1:0]    mem_ram [MEM_WORDS];
    logic [MEM_WORDS-1:0] mem_vld_reg;
    logic [DATA_W-1:0]    mem_q_reg;
    logic                 mem_qv_reg;

    logic [DATA_W-1:0]    rf_ram [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;
    logic [DATA_W-1:0]    rfa_q_reg;
    logic                 rfa_qv_reg;
    logic [DATA_W-1:0]    rfb_q_reg;
    logic                 rfb_qv_reg;

    logic [IN_ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0]    wdata_reg;
    logic [DATA_W-1:0]    rdata_reg;
    logic [DATA_W-1:0]    ir_reg;
    logic [DATA_W-1:0]    acc_reg;
    logic [MAW-1:0]       pc_reg;
    logic [MAW-1:0]       pc_next;
    logic                 halt_reg;
    logic                 halt_next;

    logic [PC_OUT_W-1:0]  out_pc_reg;
    logic                 out_halt_reg;
    logic [DATA_W-1:0]    out_rdata_reg;
    logic [DATA_W-1:0]    out_acc_reg;

    logic [7:0]           host_mod;
    logic [7:0]           tgt_mod;
    logic [7:0]           rt_mod;
    logic [7:0]           rs_mod;
    logic [MAW-1:0]       host_idx;
    logic [MAW-1:0]       tgt_idx;
    logic [MAW-1:0]       pc_inc;
    logic [RIW-1:0]       rt_idx;
    logic [RIW-1:0]       rs_idx;
    logic [OPC_W-1:0]     opcode;
    logic [7:0]           pc_wide;

    logic [DATA_W-1:0]    mem_word;
    logic [DATA_W-1:0]    op_a;
    logic [DATA_W-1:0]    op_b;
    logic [2*DATA_W-1:0]  product;
    logic [MAW-1:0]       mem_ra;
    logic                 mem_we;
    logic [MAW-1:0]       mem_wa;
    logic [DATA_W-1:0]    mem_wd;
    logic                 rf_we;
    logic [RIW-1:0]       rf_wa;
    logic [DATA_W-1:0]    rf_wd;

    logic                 div_done;
    logic [DATA_W-1:0]    div_quo;

    assign host_mod = wrap_mod({2'b0, addr_reg}, MEM_MOD);
    assign tgt_mod  = wrap_mod(ir_reg[7:0], MEM_MOD);
    assign rt_mod   = wrap_mod({4'b0, ir_reg[7:4]}, REG_MOD);
    assign rs_mod   = wrap_mod({4'b0, ir_reg[3:0]}, REG_MOD);
    assign host_idx = host_mod[MAW-1:0];
    assign tgt_idx  = tgt_mod[MAW-1:0];
    assign rt_idx   = rt_mod[RIW-1:0];
    assign rs_idx   = rs_mod[RIW-1:0];
    assign opcode   = ir_reg[DATA_W-1:DATA_W-OPC_W];
    assign pc_inc   = (pc_reg == PC_LAST) ? '0 : pc_reg + 1'b1;

    // Entries never written since reset read as zero.
    assign mem_word = mem_qv_reg ? mem_q_reg : '0;
    assign op_a     = rfa_qv_reg ? rfa_q_reg : '0;
    assign op_b     = rfb_qv_reg ? rfb_q_reg : '0;
    assign product  = op_a * op_b;

    always_comb begin
        if (cmd.host_rd) begin
            mem_ra = host_idx;
        end else if (cmd.fetch) begin
            mem_ra = pc_reg;
        end else begin
            mem_ra = tgt_idx;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = host_idx;
        mem_wd    = wdata_reg;
        rf_we     = 1'b0;
        rf_wa     = rt_idx;
        rf_wd     = op_b;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        if (cmd.host_wr) begin
            mem_we = 1'b1;
        end
        if (cmd.div_wr) begin
            rf_we = 1'b1;
            rf_wd = div_quo;
        end
        if (cmd.exec) begin
            pc_next = pc_inc;
            case (opcode)
                OP_MOV: begin
                    rf_we = 1'b1;
                    rf_wd = op_b;
                end
                OP_ADD: begin
                    rf_we = 1'b1;
                    rf_wd = op_a + op_b;
                end
                OP_SUB: begin
                    rf_we = 1'b1;
                    rf_wd = op_a - op_b;
                end
                OP_MUL: begin
                    rf_we = 1'b1;
                    rf_wd = product[DATA_W-1:0];
                end
                OP_DIV: begin
                    rf_we = 1'b0;
                end
                OP_LOAD: begin
                    rf_we = 1'b1;
                    rf_wa = '0;
                    rf_wd = mem_word;
                end
                OP_STORE: begin
                    mem_we = 1'b1;
                    mem_wa = tgt_idx;
                    mem_wd = acc_reg;
                end
                OP_JNZ: begin
                    if (acc_reg != '0) begin
                        pc_next = tgt_idx;
                    end
                end
                OP_JMP: begin
                    pc_next = tgt_idx;
                end
                default: begin
                    halt_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ram[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem_ram[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_ram[rf_wa] <= rf_wd;
        end
        rfa_q_reg <= rf_ram[rt_idx];
        rfb_q_reg <= rf_ram[rs_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_vld_reg <= '0;
            mem_qv_reg  <= 1'b0;
            rf_vld_reg  <= '0;
            rfa_qv_reg  <= 1'b0;
            rfb_qv_reg  <= 1'b0;
            acc_reg     <= '0;
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
        end else begin
            if (mem_we) begin
                mem_vld_reg[mem_wa] <= 1'b1;
            end
            mem_qv_reg <= mem_vld_reg[mem_ra];
            if (rf_we) begin
                rf_vld_reg[rf_wa] <= 1'b1;
                if (rf_wa == '0) begin
                    acc_reg <= rf_wd;
                end
            end
            rfa_qv_reg <= rf_vld_reg[rt_idx];
            rfb_qv_reg <= rf_vld_reg[rs_idx];
            pc_reg     <= pc_next;
            halt_reg   <= halt_next;
        end
    end

    assign pc_wide = 8'(pc_reg);

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            addr_reg  <= s_address;
            wdata_reg <= s_write_data;
            rdata_reg <= '0;
        end else if (cmd.rd_cap) begin
            rdata_reg <= mem_word;
        end
        if (cmd.ir_load) begin
            ir_reg <= mem_word;
        end
        if (cmd.out_load) begin
            out_pc_reg    <= pc_wide[PC_OUT_W-1:0];
            out_halt_reg  <= halt_reg;
            out_rdata_reg <= rdata_reg;
            out_acc_reg   <= acc_reg;
        end
    end

    trcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.exec && (opcode == OP_DIV)),
        .dividend (op_a),
        .divisor  (op_b),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sts.halted   = halt_reg;
    assign sts.is_div   = (opcode == OP_DIV);
    assign sts.div_done = div_done;

    assign m_program_counter = out_pc_reg;
    assign m_halted          = out_halt_reg;
    assign m_read_data       = out_rdata_reg;
    assign m_accumulator     = out_acc_reg;

endmodule

// ===== rtl/trcs_ctrl.sv =====
module trcs_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [trcs_pkg::OPN_W-1:0]   s_operation,
    output logic                         s_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output trcs_pkg::trcs_cmd_t          cmd,
    input  trcs_pkg::trcs_sts_t          sts
);
    import trcs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_HWR    = 10'b0000000010,
        S_HRD    = 10'b0000000100,
        S_HCAP   = 10'b0000001000,
        S_FETCH  = 10'b0000010000,
        S_DECODE = 10'b0000100000,
        S_REGRD  = 10'b0001000000,
        S_EXEC   = 10'b0010000000,
        S_DIV    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } trcs_state_t;

    trcs_state_t state_reg;
    trcs_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    case (s_operation)
                        OPN_EXEC:  state_next = sts.halted ? S_DONE : S_FETCH;
                        OPN_WRITE: state_next = S_HWR;
                        OPN_READ:  state_next = S_HRD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_HWR: begin
                cmd.host_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_HRD: begin
                cmd.host_rd = 1'b1;
                state_next  = S_HCAP;
            end
            S_HCAP: begin
                cmd.rd_cap = 1'b1;
                state_next = S_DONE;
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_DECODE;
            end
            S_DECODE: begin
                cmd.ir_load = 1'b1;
                state_next  = S_REGRD;
            end
            S_REGRD: begin
                cmd.reg_rd = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.is_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.div_wr = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/tiny_register_cpu_step.sv =====
// A tiny 16-bit processor with a register file and one memory shared by
// instructions and data. Each input beat either writes a memory word, reads
// one back, or executes the single instruction at the program counter, and
// every input beat yields exactly one result beat carrying the program
// counter, the halt flag, the word read (zero unless the beat was a read)
// and register zero. An execute while halted and an unused operation code
// change no state but still yield their result beat. A divide occupies the
// block longest, as the divider produces one quotient bit per cycle; the
// single read port of the shared memory sets the fetch and decode steps, and
// the registered register file read sets the operand step. The
// next input beat is taken as soon as the previous result sits in the output
// register, even if the consumer has not yet taken it. Memory and register
// file come out of reset reading as zero through per-entry valid bits, so no
// clearing pass is needed and the block is ready as soon as reset is
// released.
module tiny_register_cpu_step #(
    parameter int MEM_WORDS = trcs_pkg::MEM_WORDS_DEF,
    parameter int REG_COUNT = trcs_pkg::REG_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [trcs_pkg::OPN_W-1:0]      s_operation,
    input  logic [trcs_pkg::IN_ADDR_W-1:0]  s_address,
    input  logic [trcs_pkg::DATA_W-1:0]     s_write_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [trcs_pkg::PC_OUT_W-1:0]   m_program_counter,
    output logic                            m_halted,
    output logic [trcs_pkg::DATA_W-1:0]     m_read_data,
    output logic [trcs_pkg::DATA_W-1:0]     m_accumulator
);
    import trcs_pkg::*;

    // Commands and status between the sequencer and the datapath.
    trcs_cmd_t cmd;
    trcs_sts_t sts;

    // The controller steps through fetch, decode, operand read, execute and, for
    // a divide, a wait on the divider, or through the short host access sequences.
    trcs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    // The datapath holds the memory, the register file, the program counter,
    // the halt flag, the divider and the output register.
    trcs_datapath #(
        .MEM_WORDS (MEM_WORDS),
        .REG_COUNT (REG_COUNT)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_address         (s_address),
        .s_write_data      (s_write_data),
        .m_program_counter (m_program_counter),
        .m_halted          (m_halted),
        .m_read_data       (m_read_data),
        .m_accumulator     (m_accumulator)
    );

    // Only one item is in flight: right after a beat is taken the block is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is still in progress");

    // Once halted, the processor stays halted until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.halted |=> sts.halted)
        else $error("halt flag cleared without reset");

    // The shared memory has one read port: at most one access command at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.host_wr, cmd.host_rd, cmd.fetch, cmd.reg_rd, cmd.exec}))
        else $error("conflicting memory commands in one cycle");

    // A divide result is written back only while the sequencer awaits it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_wr |-> (sts.is_div && sts.div_done && !s_ready))
        else $error("divider write-back outside a divide");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the tiny register processor. Every accepted input
// beat is run through a shadow copy of the processor kept in this module, and
// the status it works out is queued. Each result beat is then compared, field
// by field, against the oldest queued status. Both handshakes are idled at
// random, apart from one long stretch in the middle of the random programmes
// where neither side holds back.
module tb;

    import trcs_pkg::*;

    localparam int MEM_WORDS = trcs_pkg::MEM_WORDS_DEF;
    localparam int REG_COUNT = trcs_pkg::REG_COUNT_DEF;

    // The fourth operation code has no name in the package. The block treats
    // it as a no-op that still reports status.
    localparam logic [OPN_W-1:0] OPN_IDLE = 2'd3;

    // Least number of counted beats in the random part, and how many cycles to
    // keep watching for stray result beats once the last status has been matched.
    localparam int RANDOM_BEATS = 1510;
    localparam int SETTLE_CYCLES = 40;

    // One status beat as the block reports it.
    typedef struct packed {
        logic [PC_OUT_W-1:0] pc;
        logic                halted;
        logic [DATA_W-1:0]   rdata;
        logic [DATA_W-1:0]   acc;
    } cpu_status_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [OPN_W-1:0]     s_operation;
    logic [IN_ADDR_W-1:0] s_address;
    logic [DATA_W-1:0]    s_write_data;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PC_OUT_W-1:0]  m_program_counter;
    logic                 m_halted;
    logic [DATA_W-1:0]    m_read_data;
    logic [DATA_W-1:0]    m_accumulator;

    // Shadow processor state, advanced once for every accepted input beat.
    logic [DATA_W-1:0]   sh_reg [REG_COUNT];
    logic [DATA_W-1:0]   sh_mem [MEM_WORDS];
    logic [PC_OUT_W-1:0] sh_pc;
    logic                sh_halt;

    cpu_status_t status_queue[$];
    int          mismatch_count = 0;
    int          counted_beats = 0;
    bit          no_idle = 1'b0;

    tiny_register_cpu_step dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_address         (s_address),
        .s_write_data      (s_write_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_program_counter (m_program_counter),
        .m_halted          (m_halted),
        .m_read_data       (m_read_data),
        .m_accumulator     (m_accumulator)
    );

    // 8 ns clock, low for the first half period.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // The consumer stalls at random with a chance of about 22 in a hundred, except during
    // the stretch where idling is switched off.
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= 22);
    end

    // Works out the status that one beat produces and advances the shadow
    // state. Memory and jump addresses wrap to the memory size, register
    // indexes to the register count, and a halted core ignores executes.
    function automatic cpu_status_t shadow_cpu_step(input logic [OPN_W-1:0] opn,
                                                    input logic [IN_ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] wdata);
        cpu_status_t st;
        logic [DATA_W-1:0] word;
        logic [OPC_W-1:0]  opc;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        int                rt;
        int                rs;
        int                tgt;
        bit                jumped;
        st.rdata = '0;
        case (opn)
            OPN_EXEC: begin
                if (!sh_halt) begin
                    word   = sh_mem[sh_pc];
                    opc    = word[15:8];
                    rt     = int'(word[7:4]) % REG_COUNT;
                    rs     = int'(word[3:0]) % REG_COUNT;
                    tgt    = int'(word[7:0]) % MEM_WORDS;
                    a      = sh_reg[rt];
                    b      = sh_reg[rs];
                    jumped = 1'b0;
                    case (opc)
                        OP_MOV:   sh_reg[rt] = b;
                        OP_ADD:   sh_reg[rt] = a + b;
                        OP_SUB:   sh_reg[rt] = a - b;
                        OP_MUL:   sh_reg[rt] = a * b;
                        OP_DIV:   sh_reg[rt] = (b == '0) ? '1 : a / b;
                        OP_LOAD:  sh_reg[0] = sh_mem[tgt];
                        OP_STORE: sh_mem[tgt] = sh_reg[0];
                        OP_JNZ: begin
                            if (sh_reg[0] != '0) begin
                                sh_pc  = PC_OUT_W'(tgt);
                                jumped = 1'b1;
                            end
                        end
                        OP_JMP: begin
                            sh_pc  = PC_OUT_W'(tgt);
                            jumped = 1'b1;
                        end
                        default: sh_halt = 1'b1;
                    endcase
                    if (!jumped) begin
                        sh_pc = PC_OUT_W'((int'(sh_pc) + 1) % MEM_WORDS);
                    end
                end
            end
            OPN_WRITE: sh_mem[int'(addr) % MEM_WORDS] = wdata;
            OPN_READ:  st.rdata = sh_mem[int'(addr) % MEM_WORDS];
            default: ;
        endcase
        st.pc     = sh_pc;
        st.halted = sh_halt;
        st.acc    = sh_reg[0];
        return st;
    endfunction

    // A random instruction that never halts the core. One time in eight the
    // two register fields are made equal, which gives self-subtraction to zero,
    // division by itself and moves onto the same register.
    function automatic logic [DATA_W-1:0] random_instruction();
        logic [OPC_W-1:0] opc;
        logic [3:0]       rt;
        logic [3:0]       rs;
        opc = OPC_W'($urandom_range(OP_MOV, OP_JMP));
        rt  = 4'($urandom);
        rs  = ($urandom_range(0, 7) == 0) ? rt : 4'($urandom);
        return {opc, rt, rs};
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("[%0t] bad %s: got %h, wanted %h", $realtime, what, got, want);
        end
    endtask

    // Sends one input beat. It is entered just after a rising edge and returns
    // at the edge that accepted the beat, with valid still high, so that a
    // following beat can go straight out without lowering valid in between.
    task automatic send_beat(input logic [OPN_W-1:0] opn,
                             input logic [IN_ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
        int gap;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 22) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= opn;
        s_address    <= addr;
        s_write_data <= wdata;
        do @(posedge aclk); while (!s_ready);
        status_queue.push_back(shadow_cpu_step(opn, addr, wdata));
        if (opn != OPN_IDLE) counted_beats++;
    endtask

    // Executes the instruction at the program counter. Should that word hold
    // an opcode that would halt the core, a valid instruction is written over
    // it first, since the halt is sticky until reset. The unused address and
    // data fields carry random values to show that they are ignored.
    task automatic step_program();
        if (sh_mem[sh_pc][15:8] > OP_JMP) begin
            send_beat(OPN_WRITE, sh_pc, random_instruction());
        end
        send_beat(OPN_EXEC, IN_ADDR_W'($urandom), DATA_W'($urandom));
    endtask

    // Straight after reset, memory reads as zero at both ends of the range.
    task automatic test_reset_state();
        send_beat(OPN_READ, 6'd0, 16'hFFFF);
        send_beat(OPN_READ, 6'd63, 16'h0000);
    endtask

    // A short programme that uses every opcode at least once: the add wraps
    // past the top, the subtract wraps below zero, the multiply keeps only the
    // low half, one divide has a zero divisor, the store target and both jump
    // targets lie beyond the memory and wrap, and the run ends on an all-zero
    // word at the top address so that the program counter wraps to zero.
    task automatic test_instruction_set();
        logic [DATA_W-1:0] prog [11];
        prog[0]  = {OP_LOAD, 8'd40};
        prog[1]  = {OP_MOV, 4'd1, 4'd0};
        prog[2]  = {OP_LOAD, 8'd41};
        prog[3]  = {OP_ADD, 4'd1, 4'd0};
        prog[4]  = {OP_SUB, 4'd1, 4'd0};
        prog[5]  = {OP_MUL, 4'd1, 4'd1};
        prog[6]  = {OP_DIV, 4'd1, 4'd0};
        prog[7]  = {OP_DIV, 4'd0, 4'd2};
        prog[8]  = {OP_STORE, 8'hF0};
        prog[9]  = {OP_JNZ, 8'h4B};
        prog[10] = {OP_JMP, 8'hBF};
        send_beat(OPN_WRITE, 6'd40, 16'hFFFF);
        send_beat(OPN_WRITE, 6'd41, 16'h0003);
        for (int i = 0; i < 11; i++) begin
            send_beat(OPN_WRITE, (i == 10) ? 6'd11 : IN_ADDR_W'(i), prog[i]);
        end
        repeat (12) send_beat(OPN_EXEC, '0, '0);
        send_beat(OPN_READ, 6'd48, '0);
    endtask

    // The unused operation code with every other field at its maximum.
    task automatic test_unused_operation();
        send_beat(OPN_IDLE, 6'd63, 16'hFFFF);
    endtask

    // Random programmes: a block of valid instructions is written from the
    // program counter onwards and then stepped through, with reads slipped in
    // between. Lone writes of arbitrary words, lone reads and unused codes act
    // as noise, and may well land on the programme that is running.
    task automatic test_random_programs();
        int start;
        int run;
        int len;
        int steps;
        start = counted_beats;
        while (counted_beats - start < RANDOM_BEATS) begin
            run     = counted_beats - start;
            no_idle = (run >= 500) && (run < 850);
            case ($urandom_range(0, 9))
                0: send_beat(OPN_WRITE, IN_ADDR_W'($urandom), DATA_W'($urandom));
                1: send_beat(OPN_READ, IN_ADDR_W'($urandom), DATA_W'($urandom));
                2: begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_beat(OPN_IDLE, IN_ADDR_W'($urandom), DATA_W'($urandom));
                    end else begin
                        send_beat(OPN_READ, sh_pc, DATA_W'($urandom));
                    end
                end
                default: begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        send_beat(OPN_WRITE, IN_ADDR_W'((int'(sh_pc) + i) % MEM_WORDS),
                                  random_instruction());
                    end
                    steps = $urandom_range(len, 2 * len);
                    for (int i = 0; i < steps; i++) begin
                        if ($urandom_range(0, 5) == 0) begin
                            send_beat(OPN_READ, IN_ADDR_W'($urandom), DATA_W'($urandom));
                        end
                        step_program();
                    end
                end
            endcase
        end
        no_idle = 1'b0;
    endtask

    // The halt flag cannot be cleared without a reset, so this comes last.
    // The halting opcode is either the one just above the jump or any higher
    // value. Afterwards executes must change nothing, whilst host writes,
    // reads and the unused code go on working as before.
    task automatic test_halt_and_after();
        logic [OPC_W-1:0]     bad_opc;
        logic [IN_ADDR_W-1:0] spot;
        logic [DATA_W-1:0]    word;
        bad_opc = ($urandom_range(0, 1) == 0) ? OP_JMP + 8'd1
                                              : OPC_W'($urandom_range(OP_JMP + 1, 255));
        spot    = IN_ADDR_W'($urandom);
        word    = DATA_W'($urandom);
        send_beat(OPN_WRITE, sh_pc, {bad_opc, 8'($urandom)});
        send_beat(OPN_EXEC, '0, '0);
        send_beat(OPN_EXEC, 6'd63, 16'hFFFF);
        send_beat(OPN_WRITE, spot, word);
        send_beat(OPN_READ, spot, '0);
        send_beat(OPN_WRITE, sh_pc, random_instruction());
        send_beat(OPN_EXEC, '0, '0);
        send_beat(OPN_IDLE, '0, '0);
    endtask

    // Every result beat taken by the consumer is matched against the oldest
    // queued status. Outputs are sampled at the edge, before the block's own
    // updates for that edge land.
    always @(posedge aclk) begin
        cpu_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_queue.size() == 0) begin
                report_mismatch("beat with nothing pending, pc", 16'(m_program_counter), '0);
            end else begin
                want = status_queue.pop_front();
                if (m_program_counter !== want.pc)
                    report_mismatch("program_counter", 16'(m_program_counter), 16'(want.pc));
                if (m_halted !== want.halted)
                    report_mismatch("halted", 16'(m_halted), 16'(want.halted));
                if (m_read_data !== want.rdata)
                    report_mismatch("read_data", m_read_data, want.rdata);
                if (m_accumulator !== want.acc)
                    report_mismatch("accumulator", m_accumulator, want.acc);
            end
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_operation  <= OPN_EXEC;
        s_address    <= '0;
        s_write_data <= '0;
        foreach (sh_reg[i]) sh_reg[i] = '0;
        foreach (sh_mem[i]) sh_mem[i] = '0;
        sh_pc   = '0;
        sh_halt = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_instruction_set();
        test_unused_operation();
        test_random_programs();
        test_halt_and_after();

        // All beats are in. Drop valid, let every status drain and then give
        // the block a little longer in case it emits a beat it should not.
        s_valid <= 1'b0;
        while (status_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog, sized for well over the slowest legal run: every beat a
    // divide, plus the longest gaps on both sides.
    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
